// File: rtl/cwnd_pkg.sv
// cwnd_pkg: shared types, constants and helper functions for the congestion window block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cwnd_pkg;

    localparam int WIN_BITS     = 32;
    localparam int SEG_BITS     = 16;
    localparam int PROD_BITS    = 2 * SEG_BITS;
    localparam int FIELD_BITS   = 32;
    localparam int DUP_BITS     = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int MUL_CNT_BITS = $clog2(SEG_BITS);
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS);
    localparam int WIDE_BITS    = 65;

    localparam logic [WIDE_BITS-1:0] WIN_LIM =
        (WIDE_BITS'(1) << WIN_BITS) - WIDE_BITS'(1);

    localparam logic [DUP_BITS-1:0] DUP_LIMIT = DUP_BITS'(3);
    localparam logic [DUP_BITS-1:0] DUP_SAT   = {DUP_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_SIZE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_WIN  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_THR  = CFG_IDX_BITS'(2);

    localparam logic [SEG_BITS-1:0]   RST_SEG_SIZE = SEG_BITS'(1024);
    localparam logic [FIELD_BITS-1:0] RST_INIT_WIN = FIELD_BITS'(1024);
    localparam logic [FIELD_BITS-1:0] RST_INIT_THR = FIELD_BITS'(65535);

    typedef enum logic [1:0] {
        PH_BEGIN   = 2'd0,
        PH_SLOW    = 2'd1,
        PH_AVOID   = 2'd2,
        PH_RECOVER = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        NOTE_NONE    = 2'd0,
        NOTE_SLOW    = 2'd1,
        NOTE_AVOID   = 2'd2,
        NOTE_RECOVER = 2'd3
    } t_note;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_status;

    function automatic logic [WIN_BITS-1:0] clamp_win(input logic [FIELD_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        if (w > WIN_LIM) begin
            return WIN_BITS'(WIN_LIM);
        end
        return WIN_BITS'(w);
    endfunction

    function automatic logic [WIN_BITS-1:0] sat_add(input logic [WIN_BITS-1:0] a,
                                                     input logic [WIDE_BITS-1:0] b);
        logic [WIDE_BITS-1:0] s;
        s = WIDE_BITS'(a) + b;
        if (s > WIN_LIM) begin
            return WIN_BITS'(WIN_LIM);
        end
        return WIN_BITS'(s);
    endfunction

endpackage

`default_nettype wire

// File: rtl/cwnd_mul.sv
// cwnd_mul: bit-serial shift-add squarer for the segment size
// depends on cwnd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cwnd_mul (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [cwnd_pkg::SEG_BITS-1:0]  i_seg,
    output cwnd_pkg::t_ser_status               o_sts,
    output logic [cwnd_pkg::PROD_BITS-1:0]      o_prod
);

    logic                              r_busy;
    logic                              r_done;
    logic [cwnd_pkg::MUL_CNT_BITS-1:0] r_cnt;
    logic [cwnd_pkg::PROD_BITS-1:0]    r_mcand;
    logic [cwnd_pkg::SEG_BITS-1:0]     r_mplier;
    logic [cwnd_pkg::PROD_BITS-1:0]    r_acc;
    logic                              last;

    assign last = (r_cnt == cwnd_pkg::MUL_CNT_BITS'(cwnd_pkg::SEG_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= cwnd_pkg::PROD_BITS'(i_seg);
            r_mplier <= i_seg;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

`default_nettype wire

// File: rtl/cwnd_div.sv
// cwnd_div: restoring divider, one quotient bit per cycle
// depends on cwnd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cwnd_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [cwnd_pkg::PROD_BITS-1:0] i_num,
    input  wire logic [cwnd_pkg::WIN_BITS-1:0]  i_den,
    output cwnd_pkg::t_ser_status               o_sts,
    output logic [cwnd_pkg::PROD_BITS-1:0]      o_quo
);

    logic                              r_busy;
    logic                              r_done;
    logic [cwnd_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [cwnd_pkg::PROD_BITS-1:0]    r_num;
    logic [cwnd_pkg::WIN_BITS:0]       r_rem;
    logic [cwnd_pkg::WIN_BITS-1:0]     r_den;
    logic [cwnd_pkg::WIN_BITS:0]       rem_sh;
    logic                              q_bit;
    logic                              last;

    assign last   = (r_cnt == cwnd_pkg::DIV_CNT_BITS'(cwnd_pkg::PROD_BITS - 1));
    assign rem_sh = {r_rem[cwnd_pkg::WIN_BITS-1:0], r_num[cwnd_pkg::PROD_BITS-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_num <= {r_num[cwnd_pkg::PROD_BITS-2:0], q_bit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_num;

endmodule

`default_nettype wire

// File: rtl/tcp_reno_congestion_window.sv
// tcp_reno_congestion_window: reno phase controller with serial avoidance increment
// depends on cwnd_pkg, cwnd_mul and cwnd_div
// serial increment on a new or delayed ack in avoidance with a nonzero window:
// bit-serial square of the segment size, then a restoring divide by the window
// throughput: one item per cycle when idle and output not stalled, none during an increment
// reset: synchronous active low, begin phase, zero window and threshold, config registers at defaults
`timescale 1ns / 1ps
`default_nettype none

module tcp_reno_congestion_window (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cwnd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [cwnd_pkg::FIELD_BITS-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_new_ack,
    input  wire logic                              i_dup_ack,
    input  wire logic                              i_timed_out,
    input  wire logic                              i_delayed_ack,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [cwnd_pkg::FIELD_BITS-1:0]        o_window,
    output logic [cwnd_pkg::FIELD_BITS-1:0]        o_threshold,
    output logic [1:0]                             o_phase,
    output logic [cwnd_pkg::DUP_BITS-1:0]          o_dup_count,
    output logic [1:0]                             o_phase_note
);

    logic [cwnd_pkg::SEG_BITS-1:0]   r_seg;
    logic [cwnd_pkg::FIELD_BITS-1:0] r_init_win;
    logic [cwnd_pkg::FIELD_BITS-1:0] r_init_thr;

    cwnd_pkg::t_state                r_state, n_state;
    cwnd_pkg::t_phase                r_phase, n_phase;
    logic [cwnd_pkg::WIN_BITS-1:0]   r_window, n_window;
    logic [cwnd_pkg::WIN_BITS-1:0]   r_thr, n_thr;
    logic [cwnd_pkg::DUP_BITS-1:0]   r_dup, n_dup;

    logic                            r_out_valid, n_out_valid;
    logic [cwnd_pkg::FIELD_BITS-1:0] r_out_window, r_out_thr;
    cwnd_pkg::t_phase                r_out_phase;
    logic [cwnd_pkg::DUP_BITS-1:0]   r_out_dup;
    cwnd_pkg::t_note                 r_out_note;

    cwnd_pkg::t_note                 note;
    logic                            load_out;
    logic                            accept;
    logic                            nack;
    logic                            serial;
    logic                            mul_start;
    logic                            div_start;

    cwnd_pkg::t_ser_status           mul_sts, div_sts;
    logic [cwnd_pkg::PROD_BITS-1:0]  prod;
    logic [cwnd_pkg::PROD_BITS-1:0]  quo;

    logic [cwnd_pkg::WIN_BITS-1:0]   half_win;
    logic [cwnd_pkg::WIDE_BITS-1:0]  seg_w;
    logic [cwnd_pkg::WIDE_BITS-1:0]  seg3_w;
    logic [cwnd_pkg::DUP_BITS-1:0]   dup_inc;

    assign o_in_ready = (r_state == cwnd_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign nack       = i_new_ack || i_delayed_ack;

    assign half_win = r_window >> 1;
    assign seg_w    = cwnd_pkg::WIDE_BITS'(r_seg);
    assign seg3_w   = (seg_w << 1) + seg_w;
    assign dup_inc  = (r_dup == cwnd_pkg::DUP_SAT) ? r_dup : r_dup + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg      <= cwnd_pkg::RST_SEG_SIZE;
            r_init_win <= cwnd_pkg::RST_INIT_WIN;
            r_init_thr <= cwnd_pkg::RST_INIT_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cwnd_pkg::CFG_SEG_SIZE: r_seg      <= i_cfg_data[cwnd_pkg::SEG_BITS-1:0];
                cwnd_pkg::CFG_INIT_WIN: r_init_win <= i_cfg_data;
                cwnd_pkg::CFG_INIT_THR: r_init_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_window    = r_window;
        n_thr       = r_thr;
        n_dup       = r_dup;
        note        = cwnd_pkg::NOTE_NONE;
        serial      = 1'b0;
        load_out    = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;

        case (r_state)
            cwnd_pkg::ST_IDLE: begin
                if (accept) begin
                    case (r_phase)
                        cwnd_pkg::PH_BEGIN: begin
                            n_phase  = cwnd_pkg::PH_SLOW;
                            n_window = cwnd_pkg::clamp_win(r_init_win);
                            n_thr    = cwnd_pkg::clamp_win(r_init_thr);
                        end
                        cwnd_pkg::PH_SLOW: begin
                            if (r_window >= r_thr) begin
                                n_phase = cwnd_pkg::PH_AVOID;
                                note    = cwnd_pkg::NOTE_AVOID;
                            end else if (r_dup == cwnd_pkg::DUP_LIMIT) begin
                                n_phase  = cwnd_pkg::PH_RECOVER;
                                note     = cwnd_pkg::NOTE_RECOVER;
                                n_thr    = half_win;
                                n_window = cwnd_pkg::sat_add(half_win, seg3_w);
                            end else if (nack) begin
                                n_window = cwnd_pkg::sat_add(r_window, seg_w);
                                n_dup    = '0;
                            end else if (i_dup_ack) begin
                                n_dup = dup_inc;
                            end else if (i_timed_out) begin
                                n_thr    = half_win;
                                n_window = cwnd_pkg::clamp_win(cwnd_pkg::FIELD_BITS'(r_seg));
                                n_dup    = '0;
                            end
                        end
                        cwnd_pkg::PH_AVOID: begin
                            if (i_timed_out) begin
                                n_phase  = cwnd_pkg::PH_SLOW;
                                note     = cwnd_pkg::NOTE_SLOW;
                                n_thr    = half_win;
                                n_window = cwnd_pkg::clamp_win(cwnd_pkg::FIELD_BITS'(r_seg));
                                n_dup    = '0;
                            end else if (i_dup_ack) begin
                                n_dup = dup_inc;
                            end else if (r_dup == cwnd_pkg::DUP_LIMIT) begin
                                n_phase  = cwnd_pkg::PH_RECOVER;
                                note     = cwnd_pkg::NOTE_RECOVER;
                                n_thr    = half_win;
                                n_window = cwnd_pkg::sat_add(half_win, seg3_w);
                            end else if (nack) begin
                                n_dup  = '0;
                                serial = (r_window != '0);
                            end
                        end
                        default: begin
                            if (i_timed_out) begin
                                n_phase  = cwnd_pkg::PH_SLOW;
                                note     = cwnd_pkg::NOTE_SLOW;
                                n_thr    = half_win;
                                n_window = cwnd_pkg::clamp_win(cwnd_pkg::FIELD_BITS'(r_seg));
                                n_dup    = '0;
                            end else if (nack) begin
                                n_phase  = cwnd_pkg::PH_AVOID;
                                note     = cwnd_pkg::NOTE_AVOID;
                                n_window = r_thr;
                                n_dup    = '0;
                            end else if (i_dup_ack) begin
                                n_window = cwnd_pkg::sat_add(r_window, seg_w);
                            end
                        end
                    endcase
                    if (serial) begin
                        mul_start = 1'b1;
                        n_state   = cwnd_pkg::ST_MUL;
                    end else begin
                        load_out = 1'b1;
                    end
                end
            end
            cwnd_pkg::ST_MUL: begin
                if (mul_sts.done) begin
                    div_start = 1'b1;
                    n_state   = cwnd_pkg::ST_DIV;
                end
            end
            cwnd_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_window = cwnd_pkg::sat_add(r_window, cwnd_pkg::WIDE_BITS'(quo));
                    load_out = 1'b1;
                    n_state  = cwnd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cwnd_pkg::ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwnd_pkg::ST_IDLE;
            r_phase     <= cwnd_pkg::PH_BEGIN;
            r_window    <= '0;
            r_thr       <= '0;
            r_dup       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_thr       <= n_thr;
            r_dup       <= n_dup;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_window <= cwnd_pkg::FIELD_BITS'(n_window);
            r_out_thr    <= cwnd_pkg::FIELD_BITS'(n_thr);
            r_out_phase  <= n_phase;
            r_out_dup    <= n_dup;
            r_out_note   <= note;
        end
    end

    cwnd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_seg   (r_seg),
        .o_sts   (mul_sts),
        .o_prod  (prod)
    );

    cwnd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (r_window),
        .o_sts   (div_sts),
        .o_quo   (quo)
    );

    assign o_out_valid  = r_out_valid;
    assign o_window     = r_out_window;
    assign o_threshold  = r_out_thr;
    assign o_phase      = r_out_phase;
    assign o_dup_count  = r_out_dup;
    assign o_phase_note = r_out_note;

    // increment path only runs in avoidance with a nonzero window
    a_serial_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cwnd_pkg::ST_IDLE) |-> (r_phase == cwnd_pkg::PH_AVOID && r_window != '0))
        else $error("serial increment outside avoidance");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_sts.done |-> (r_state == cwnd_pkg::ST_MUL && !div_sts.busy))
        else $error("multiplier done out of sequence");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == cwnd_pkg::ST_DIV && !mul_sts.busy))
        else $error("divider done out of sequence");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_out_valid) |-> i_out_ready)
        else $error("pending item overwritten");

endmodule

`default_nettype wire
